@@ src/epd_pkg.sv @@
// ----------------------------------------------------------------------------
// epd_pkg
// Types and constants shared by the excursion peak/trough detector and its
// port checker.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 16;
  localparam int OUT_BITS    = 16;
  localparam int THRESH_BITS = 16;

  localparam logic [OUT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_UNDECIDED   = 2'd0,
    MODE_SEEK_PEAK   = 2'd1,
    MODE_SEEK_TROUGH = 2'd2
  } search_mode_t;

  localparam logic KIND_PEAK   = 1'b0;
  localparam logic KIND_TROUGH = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last_sample;
  } sample_item_t;

  typedef struct packed {
    logic                       event_kind;
    logic [OUT_BITS-1:0]        event_index;
    logic signed [OUT_BITS-1:0] event_value;
    logic [OUT_BITS-1:0]        kind_count;
  } event_item_t;

endpackage

@@ src/excursion_peak_trough_detector_core.sv @@
// ----------------------------------------------------------------------------
// excursion_peak_trough_detector_core
// Tracks running max/min of each record and reports a peak or trough once
// the signal has moved away from it by at least the programmed threshold.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------
//   in       | in        | in_valid / in_ready    | sample_item_t
//   out      | out       | out_valid / out_ready  | event_item_t
//   cfg      | in        | cfg_write (no wait)    | threshold
//
// One sample per cycle while in_ready is high; each accepted sample updates the tracking state in
// the same cycle and loads at most one event into the output register.
// The event appears on out in the cycle after its sample is accepted.
// in_ready is high while the output register is empty or being emptied, so
// a stalled out side stalls in only once an event is waiting.
// rst (synchronous) clears the threshold, all tracking state and out_valid.
// ----------------------------------------------------------------------------
module excursion_peak_trough_detector_core
  import epd_pkg::*;
#(
  parameter int INDEX_W = INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [THRESH_BITS-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sample_item_t           in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output event_item_t            out_item
);

  localparam int EXT_W = SAMPLE_BITS + 2;

  logic [THRESH_BITS-1:0]        threshold;
  search_mode_t                  search_mode, search_mode_next;
  logic                          record_open;
  logic signed [SAMPLE_BITS-1:0] max_value, max_value_next;
  logic signed [SAMPLE_BITS-1:0] min_value, min_value_next;
  logic [INDEX_W-1:0]            max_index, max_index_next;
  logic [INDEX_W-1:0]            min_index, min_index_next;
  logic [INDEX_W-1:0]            sample_counter;
  logic [OUT_BITS-1:0]           peaks_found, peaks_found_next;
  logic [OUT_BITS-1:0]           troughs_found, troughs_found_next;
  event_item_t                   result, result_next;
  logic                          result_valid, emit;

  // working view of the state, with a record start folded in
  search_mode_t                  cur_mode;
  logic signed [SAMPLE_BITS-1:0] cur_max, cur_min;
  logic [INDEX_W-1:0]            cur_max_idx, cur_min_idx, idx;
  logic [OUT_BITS-1:0]           cur_peaks, cur_troughs;
  logic signed [EXT_W-1:0]       x_ext, e_ext, max_ext, min_ext;
  logic                          fall_hit, rise_hit;
  logic [31:0]                   max_idx_wide, min_idx_wide;
  logic                          accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !result_valid || out_ready;
  assign out_valid = result_valid;
  assign out_item  = result;

  always_comb begin
    if (record_open) begin
      cur_mode    = search_mode;
      cur_max     = max_value;
      cur_min     = min_value;
      cur_max_idx = max_index;
      cur_min_idx = min_index;
      cur_peaks   = peaks_found;
      cur_troughs = troughs_found;
      idx         = sample_counter;
    end else begin
      cur_mode    = MODE_UNDECIDED;
      cur_max     = in_item.sample_value;
      cur_min     = in_item.sample_value;
      cur_max_idx = '0;
      cur_min_idx = '0;
      cur_peaks   = '0;
      cur_troughs = '0;
      idx         = '0;
    end

    x_ext   = EXT_W'(in_item.sample_value);
    e_ext   = signed'({2'b00, threshold});
    max_ext = EXT_W'(cur_max);
    min_ext = EXT_W'(cur_min);
    // full-width sums, no wrap
    fall_hit = max_ext >= (x_ext + e_ext);
    rise_hit = x_ext >= (min_ext + e_ext);

    search_mode_next   = cur_mode;
    max_value_next     = cur_max;
    min_value_next     = cur_min;
    max_index_next     = cur_max_idx;
    min_index_next     = cur_min_idx;
    peaks_found_next   = cur_peaks;
    troughs_found_next = cur_troughs;
    emit               = 1'b0;
    max_idx_wide       = 32'(cur_max_idx);
    min_idx_wide       = 32'(cur_min_idx);
    result_next        = result;

    unique case (cur_mode)
      MODE_SEEK_PEAK: begin
        if (cur_max <= in_item.sample_value) begin
          max_value_next = in_item.sample_value;
          max_index_next = idx;
        end else if (fall_hit) begin
          if (cur_peaks != COUNT_MAX) peaks_found_next = cur_peaks + 1'b1;
          emit                    = 1'b1;
          result_next.event_kind  = KIND_PEAK;
          result_next.event_index = max_idx_wide[OUT_BITS-1:0];
          result_next.event_value = cur_max;
          result_next.kind_count  = peaks_found_next;
          min_value_next   = in_item.sample_value;
          min_index_next   = idx;
          search_mode_next = MODE_SEEK_TROUGH;
        end
      end
      MODE_SEEK_TROUGH: begin
        if (in_item.sample_value <= cur_min) begin
          min_value_next = in_item.sample_value;
          min_index_next = idx;
        end else if (rise_hit) begin
          if (cur_troughs != COUNT_MAX) troughs_found_next = cur_troughs + 1'b1;
          emit                    = 1'b1;
          result_next.event_kind  = KIND_TROUGH;
          result_next.event_index = min_idx_wide[OUT_BITS-1:0];
          result_next.event_value = cur_min;
          result_next.kind_count  = troughs_found_next;
          max_value_next   = in_item.sample_value;
          max_index_next   = idx;
          search_mode_next = MODE_SEEK_PEAK;
        end
      end
      default: begin
        // undecided; the spare code behaves the same
        if (fall_hit)      search_mode_next = MODE_SEEK_TROUGH;
        else if (rise_hit) search_mode_next = MODE_SEEK_PEAK;
        else               search_mode_next = MODE_UNDECIDED;
        if (cur_max <= in_item.sample_value) begin
          max_value_next = in_item.sample_value;
          max_index_next = idx;
        end else if (in_item.sample_value <= cur_min) begin
          min_value_next = in_item.sample_value;
          min_index_next = idx;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      search_mode    <= MODE_UNDECIDED;
      record_open    <= 1'b0;
      max_value      <= '0;
      min_value      <= '0;
      max_index      <= '0;
      min_index      <= '0;
      sample_counter <= '0;
      peaks_found    <= '0;
      troughs_found  <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) threshold <= cfg_data;
      if (accept) begin
        search_mode    <= search_mode_next;
        record_open    <= !in_item.last_sample;
        max_value      <= max_value_next;
        min_value      <= min_value_next;
        max_index      <= max_index_next;
        min_index      <= min_index_next;
        sample_counter <= idx + 1'b1;
        peaks_found    <= peaks_found_next;
        troughs_found  <= troughs_found_next;
        result_valid   <= emit;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) result <= result_next;
  end

endmodule

@@ src/epd_checker.sv @@
// ----------------------------------------------------------------------------
// epd_port_assertions
// Port-level checks for the excursion peak/trough detector.
// ----------------------------------------------------------------------------
module epd_port_assertions
  import epd_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input event_item_t  out_item
);

  // a waiting event holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("event changed or dropped while stalled");

  // input side only blocks on an untaken event
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output register state");

  // a fresh event needs an accepted sample on the edge before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("event with no accepted sample");

  // counts include the event itself
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.kind_count != '0)
    else $error("zero event count");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind excursion_peak_trough_detector_core epd_port_assertions u_epd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

@@ bench/epd_checker.sv @@
// ----------------------------------------------------------------------------
// epd_checker
// Watches the sample, event and threshold ports of the peak/trough detector.
// Keeps its own copy of the tracking state, works out the event that each
// accepted sample should raise, and compares every event that leaves the
// block against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module epd_checker
  import epd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [THRESH_BITS-1:0] cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  sample_item_t           in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  event_item_t            out_item,
  output int                     fail_count,
  output int                     events_outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // predicted tracking state
  int                  threshold;
  search_mode_t        mode;
  bit                  rec_open;
  int                  max_v;
  int                  min_v;
  logic [OUT_BITS-1:0] max_i;
  logic [OUT_BITS-1:0] min_i;
  logic [OUT_BITS-1:0] sample_idx;
  logic [OUT_BITS-1:0] peaks;
  logic [OUT_BITS-1:0] troughs;

  event_item_t expected_events[$];

  task automatic clear_tracking();
    threshold = 0;
    mode      = MODE_UNDECIDED;
    rec_open  = 1'b0;
    max_v     = 0;
    min_v     = 0;
    max_i     = '0;
    min_i     = '0;
    sample_idx = '0;
    peaks     = '0;
    troughs   = '0;
  endtask

  // Applies one sample to the tracking state; fired is set when an extreme
  // gets confirmed by it.
  task automatic track_sample(input sample_item_t s, output bit fired,
                              output event_item_t ev);
    int                  x;
    logic [OUT_BITS-1:0] idx;
    x     = $signed(s.sample_value);
    fired = 1'b0;
    ev    = '0;
    if (!rec_open) begin
      rec_open   = 1'b1;
      sample_idx = '0;
      mode       = MODE_UNDECIDED;
      max_v      = x;
      min_v      = x;
      max_i      = '0;
      min_i      = '0;
      peaks      = '0;
      troughs    = '0;
    end
    idx = sample_idx;
    case (mode)
      MODE_SEEK_PEAK: begin
        if (max_v <= x) begin
          max_v = x;
          max_i = idx;
        end else if (max_v >= x + threshold) begin
          if (peaks != COUNT_MAX) peaks++;
          fired          = 1'b1;
          ev.event_kind  = KIND_PEAK;
          ev.event_index = max_i;
          ev.event_value = 16'(max_v);
          ev.kind_count  = peaks;
          min_v = x;
          min_i = idx;
          mode  = MODE_SEEK_TROUGH;
        end
      end
      MODE_SEEK_TROUGH: begin
        if (x <= min_v) begin
          min_v = x;
          min_i = idx;
        end else if (x >= min_v + threshold) begin
          if (troughs != COUNT_MAX) troughs++;
          fired          = 1'b1;
          ev.event_kind  = KIND_TROUGH;
          ev.event_index = min_i;
          ev.event_value = 16'(min_v);
          ev.kind_count  = troughs;
          max_v = x;
          max_i = idx;
          mode  = MODE_SEEK_PEAK;
        end
      end
      default: begin
        // undecided: direction chosen by the first excursion, fall wins
        if (max_v >= x + threshold) mode = MODE_SEEK_TROUGH;
        else if (x >= min_v + threshold) mode = MODE_SEEK_PEAK;
        else mode = MODE_UNDECIDED;
        if (max_v <= x) begin
          max_v = x;
          max_i = idx;
        end else if (x <= min_v) begin
          min_v = x;
          min_i = idx;
        end
      end
    endcase
    sample_idx = idx + 1'b1;
    if (s.last_sample) rec_open = 1'b0;
  endtask

  always @(posedge clk) begin
    bit          fired;
    event_item_t ev;
    event_item_t want;
    if (rst) begin
      clear_tracking();
      expected_events.delete();
      fail_count = 0;
    end else begin
      // the event leaving now belongs to an earlier sample, so pop first
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected event kind=%0d idx=%0d val=%0d cnt=%0d", $realtime,
                     out_item.event_kind, out_item.event_index,
                     out_item.event_value, out_item.kind_count);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_item.event_kind !== want.event_kind ||
              out_item.event_index !== want.event_index ||
              out_item.event_value !== want.event_value ||
              out_item.kind_count !== want.kind_count) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp k=%0d i=%0d v=%0d c=%0d got k=%0d i=%0d v=%0d c=%0d",
                       $realtime, want.event_kind, want.event_index, want.event_value,
                       want.kind_count, out_item.event_kind, out_item.event_index,
                       out_item.event_value, out_item.kind_count);
            fail_count++;
          end
        end
      end
      if (cfg_write) threshold = cfg_data;
      if (in_valid && in_ready) begin
        track_sample(in_item, fired, ev);
        if (fired) expected_events.push_back(ev);
      end
    end
    events_outstanding = expected_events.size();
  end

endmodule

@@ bench/tb_excursion_peak_trough_detector_core.sv @@
// ----------------------------------------------------------------------------
// tb_excursion_peak_trough_detector_core
// Drives records of signed samples into the peak/trough detector under a
// range of thresholds: a short directed set, then random walks with noise.
// Both handshakes stall at random; epd_checker does the prediction and
// compare.
// ----------------------------------------------------------------------------
module tb_excursion_peak_trough_detector_core;
  import epd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [THRESH_BITS-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sample_item_t           in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  event_item_t            out_item;

  int fail_count;
  int events_outstanding;
  int thr = 0;
  bit steady = 1'b0;

  always #10 clk = ~clk;

  excursion_peak_trough_detector_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  epd_checker port_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item           (out_item),
    .fail_count         (fail_count),
    .events_outstanding (events_outstanding)
  );

  // receiver stalls about 15% of cycles unless in a steady stretch
  always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= 15);

  task automatic send_sample(input int v, input bit last);
    sample_item_t s;
    s.sample_value = 16'(v);
    s.last_sample  = last;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // waits until every event is out, then lets the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_threshold(input int v);
    drain();
    thr = v;
    cfg_write <= 1'b1;
    cfg_data  <= 16'(v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // random walk with persistent direction so excursions build up, plus
  // full-range noise and rail values
  task automatic run_records(input int n_items);
    int sent;
    int len;
    int cur;
    int amp;
    int dir;
    int pick;
    sent = 0;
    amp  = (thr == 0) ? 64 : thr + thr / 2;
    if (amp > 65535) amp = 65535;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
      cur = int'($urandom_range(65535)) - 32768;
      dir = $urandom_range(1) ? 1 : -1;
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          if ($urandom_range(99) < 30) dir = -dir;
          cur += dir * int'($urandom_range(amp));
          if (cur > 32767) begin
            cur = 32767;
            dir = -1;
          end
          if (cur < -32768) begin
            cur = -32768;
            dir = 1;
          end
        end else if (pick < 92) begin
          cur = int'($urandom_range(65535)) - 32768;
        end else begin
          cur = $urandom_range(1) ? 32767 : -32768;
        end
        send_sample(cur, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // threshold still at its reset value of zero: first sample already
    // decides the direction
    send_sample(0, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(5, 1'b1);
    send_sample(-1, 1'b1);

    set_threshold(100);
    send_sample(0, 1'b0);
    send_sample(150, 1'b0);
    send_sample(150, 1'b0);
    send_sample(40, 1'b0);
    send_sample(-60, 1'b0);
    send_sample(-60, 1'b0);
    send_sample(50, 1'b0);
    send_sample(200, 1'b0);
    send_sample(99, 1'b0);
    send_sample(10, 1'b1);

    // widest threshold: only rail-to-rail swings confirm
    set_threshold(65535);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(0, 1'b1);

    set_threshold(int'($urandom_range(50, 1)));
    run_records(175);
    set_threshold(int'($urandom_range(3000, 200)));
    steady = 1'b1;
    run_records(175);
    drain();
    steady = 1'b0;
    set_threshold(0);
    run_records(175);
    set_threshold(65535);
    run_records(175);
    set_threshold(int'($urandom_range(65534, 20000)));
    run_records(175);
    set_threshold(1);
    run_records(175);
    set_threshold(int'($urandom_range(65535)));
    run_records(175);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && events_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
